### rtl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal text block.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset
`define SIDTA_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Condition that must never hold outside reset
`define SIDTA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define SIDTA_ASSERT_IMPL(label, cond, prop, msg)
`define SIDTA_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/sidta_pkg.sv
// Shared constants and types for the signed integer to decimal text block.
// No dependencies.
package sidta_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef logic [3:0] bcd_t;

  // Control shared by every cell of the digit row
  typedef struct packed {
    logic clr;
    logic bit_shift;
    logic dig_shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_t;

endpackage

### rtl/sidta_if.sv
// Valid/ready channel interfaces for the number input and the text output.
// Depends on sidta_pkg for field widths.
interface sidta_num_if;
  logic                                valid;
  logic                                ready;
  logic signed [sidta_pkg::VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidta_text_if;
  logic                          valid;
  logic                          ready;
  logic [sidta_pkg::CHAR_W-1:0]  character;
  logic                          last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

### rtl/sidta_cell.sv
// One BCD digit cell: add-3-and-shift during conversion, digit shift during output.
// Depends on sidta_pkg.
module sidta_cell (
  input  logic                  clk,
  input  sidta_pkg::cell_ctrl_t ctrl,
  input  logic                  bit_in,
  input  sidta_pkg::bcd_t       dig_in,
  output sidta_pkg::bcd_t       digit,
  output logic                  carry
);
  import sidta_pkg::*;

  bcd_t adj;

  // Correct the digit before it doubles
  always_comb begin
    adj   = (digit >= 4'd5) ? digit + 4'd3 : digit;
    carry = adj[3];
  end

  // Clear, take one bit from below, take the whole lower digit, or hold
  always_ff @(posedge clk) begin
    priority if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.bit_shift) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.dig_shift) begin
      digit <= dig_in;
    end else begin
      digit <= digit;
    end
  end

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sidta_pkg, sidta_if, sidta_cell and the assertion header.
//
// Usage: one transaction on num carries a signed 32-bit value. The block
// answers with its decimal text on text, one character per transaction,
// most significant first, a leading '-' for negative values, no leading
// zeros, and last set on the final character.
// Timing: the value is taken in the idle state, then a row of ten BCD
// cells runs add-3-and-shift steps on the magnitude, one for each of its
// 32 bits. Output then gives the sign if negative and steps through each
// of the ten digit positions, suppressed leading zeros included. The
// first character is valid once conversion ends at the earliest, later
// when leading zeros are skipped. num.ready is high only while no item is
// in conversion or output; the next value may be taken while the final
// character still waits in the output register.
// Reset clears the state machine and the output valid flag; no item in
// progress survives. A stall on text holds the output register and, once
// a character is due in output, halts the digit row until it is taken.
`include "signed_int_to_decimal_ascii_assert.svh"
module signed_int_to_decimal_ascii (
  input  logic             clk,
  input  logic             rst,
  sidta_num_if.sink        num,
  sidta_text_if.source     text
);
  import sidta_pkg::*;

  state_t               state, state_next;
  logic [VALUE_W-1:0]   mag;
  logic                 neg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [REM_W-1:0]     rem;
  logic                 started;
  logic                 ovalid;
  logic [CHAR_W-1:0]    ochar;
  logic                 olast;

  cell_ctrl_t           ctrl;
  bcd_t                 digits [NUM_DIGITS];
  logic                 carries [NUM_DIGITS];
  bcd_t                 top_digit;
  logic                 out_free;
  logic                 emit_now;
  logic                 advance;
  logic                 out_we;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;

  assign top_digit = digits[NUM_DIGITS-1];
  assign out_free  = !ovalid || text.ready;
  assign emit_now  = (top_digit != 4'd0) || started || (rem == REM_W'(1));
  assign advance   = !emit_now || out_free;

  // Digit row: cell 0 is least significant and takes the magnitude bits
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic bit_in;
    bcd_t dig_in;
    if (i == 0) begin : g_first
      assign bit_in = mag[VALUE_W-1];
      assign dig_in = '0;
    end else begin : g_rest
      assign bit_in = carries[i-1];
      assign dig_in = digits[i-1];
    end
    sidta_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .bit_in (bit_in),
      .dig_in (dig_in),
      .digit  (digits[i]),
      .carry  (carries[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (num.valid) state_next = S_CONV;
      S_CONV: if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) state_next = neg ? S_SIGN : S_EMIT;
      S_SIGN: if (out_free) state_next = S_EMIT;
      S_EMIT: if (advance && rem == REM_W'(1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    num.ready      = 1'b0;
    ctrl           = '0;
    out_we         = 1'b0;
    out_char       = CHAR_ZERO + CHAR_W'(top_digit);
    out_last       = (rem == REM_W'(1));
    unique case (state)
      S_IDLE: begin
        num.ready = 1'b1;
        ctrl.clr  = num.valid;
      end
      S_CONV: ctrl.bit_shift = 1'b1;
      S_SIGN: begin
        out_we   = out_free;
        out_char = CHAR_MINUS;
        out_last = 1'b0;
      end
      S_EMIT: begin
        ctrl.dig_shift = advance;
        out_we         = emit_now && out_free;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_we) begin
        ovalid <= 1'b1;
      end else if (text.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Datapath registers: magnitude, counters, output character
  always_ff @(posedge clk) begin
    if (state == S_IDLE && num.valid) begin
      neg     <= num.value[VALUE_W-1];
      mag     <= num.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(num.value))
                                      : VALUE_W'(num.value);
      bit_cnt <= '0;
      started <= 1'b0;
    end
    if (state == S_CONV) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      rem     <= REM_W'(NUM_DIGITS);
    end
    if (state == S_EMIT && advance) begin
      rem <= rem - REM_W'(1);
      if (emit_now) started <= 1'b1;
    end
    if (out_we) begin
      ochar <= out_char;
      olast <= out_last;
    end
  end

  assign text.valid     = ovalid;
  assign text.character = ochar;
  assign text.last      = olast;

  // Checks
  `SIDTA_ASSERT_NEVER(a_top_carry, state == S_CONV && carries[NUM_DIGITS-1], "top digit overflow")
  `SIDTA_ASSERT_IMPL(a_bcd_top, state == S_EMIT, top_digit <= 4'd9, "top digit not BCD")
  `SIDTA_ASSERT_IMPL(a_rem_live, state == S_EMIT, rem != '0, "digit count ran out")
  `SIDTA_ASSERT_IMPL(a_no_overwrite, out_we, !ovalid || text.ready, "pending character lost")

endmodule
